/* design/pbs_pkg.sv */
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types, codes and helpers of the particle step block.
// ----------------------------------------------------------------------------
package pbs_pkg;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 136;
   localparam int OPC_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int HIT_W      = 6;
   localparam int MUL_W      = 27;

   localparam logic [HIT_W-1:0] HIT_MAX     = 6'd63;
   // floor(2^32 / divisor); the quotient estimate is at most one low.
   localparam logic [MUL_W-1:0] DIV60_MUL   = 27'd71582788;
   localparam logic [MUL_W-1:0] DIV7200_MUL = 27'd596523;

   typedef enum logic [OPC_W-1:0] {
      OPC_LOAD  = 2'd0,
      OPC_FORCE = 2'd1,
      OPC_STEP  = 2'd2
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRAVITY  = 3'd0,
      CSR_BOUNCE   = 3'd1,
      CSR_FRICTION = 3'd2,
      CSR_LIMIT_X  = 3'd3,
      CSR_LIMIT_Y  = 3'd4,
      CSR_POINTS   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      DOP_DIV60,
      DOP_DIV7200,
      DOP_REFLECT
   } dop_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_INTEG,
      ST_WALL,
      ST_WALK,
      ST_HIT,
      ST_FINAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [9:0]         radius;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic busy;
      logic valid;
      logic hit;
   } ovl_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sh07FFFFFFF) begin
         return 32'sh7FFFFFFF;
      end else if (v < 36'shF80000000) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [32:0] abs33(input logic signed [31:0] v);
      return v[31] ? -33'(v) : 33'(v);
   endfunction

endpackage

/* design/particle_step_with_bounce.sv */
// ----------------------------------------------------------------------------
// particle_step_with_bounce
// Particle store with load, force and a fixed-step integrate with bounce.
// ----------------------------------------------------------------------------
// One item is worked at a time; the next is taken once the result has moved
// to the output register. In a step, the single RAM read port streams one
// stored entry per cycle, while no overlap holds the walk, into a three-stage
// distance pipeline; n entries are walked (points_in_use, at most MAX_POINTS).
// Each overlap drains the pipeline, runs four reflections through the shared
// divide unit and then reads again the entries that were in flight behind it
// before the walk goes on.
// The store has no reset; entries must be loaded before they are used.
module particle_step_with_bounce #(
   parameter int MAX_POINTS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // point_index[5:0], value_x[37:6], value_y[69:38], point_radius[79:70]
   input  logic [pbs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // opcode[1:0]
   input  logic [pbs_pkg::OPC_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96], hit_count[133:128]
   output logic [pbs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [pbs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pbs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int JW = $clog2(MAX_POINTS + 1);

   // Configuration registers.
   logic signed [31:0] grav_ff;
   logic [16:0]        bounce_ff;
   logic [30:0]        fric_ff;
   logic [15:0]        limx_ff;
   logic [15:0]        limy_ff;
   logic [6:0]         pin_ff;

   // Request fields.
   logic [5:0]         r_idx;
   logic signed [31:0] r_vx;
   logic signed [31:0] r_vy;
   logic [9:0]         r_rad;

   pbs_pkg::state_type state_ff, state_in;
   logic [2:0]         ph_ff, ph_in;
   logic [1:0]         op_ff, op_in;
   logic               inr_ff, inr_in;
   logic [AW-1:0]      i_ff, i_in;
   logic signed [31:0] valx_ff, valx_in;
   logic signed [31:0] valy_ff, valy_in;
   logic [9:0]         radi_ff, radi_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [31:0] vx_ff, vx_in;
   logic signed [31:0] vy_ff, vy_in;
   logic [9:0]         r_ff, r_in;
   logic signed [32:0] incx_ff, incx_in;
   logic signed [32:0] incy_ff, incy_in;
   logic signed [33:0] dvx_ff, dvx_in;
   logic signed [33:0] dvy_ff, dvy_in;
   logic signed [33:0] dg_ff, dg_in;
   logic signed [33:0] gv_ff, gv_in;
   logic signed [33:0] fv_ff, fv_in;
   logic               wallx_ff, wallx_in;
   logic               wally_ff, wally_in;
   logic [5:0]         hits_ff, hits_in;
   logic [JW-1:0]      n_ff, n_in;
   logic [JW-1:0]      wj_ff, wj_in;
   logic               s1_v_ff, s1_v_in;
   logic [JW-1:0]      s1_j_ff, s1_j_in;
   logic [JW-1:0]      hj_ff, hj_in;
   pbs_pkg::entry_type hent_ff, hent_in;
   logic signed [31:0] ovx_ff, ovx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [pbs_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Datapath connections.
   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   logic [AW-1:0]               ram_raddr;
   pbs_pkg::entry_type          wr_ent;
   logic [pbs_pkg::ENTRY_W-1:0] rd_word;
   pbs_pkg::entry_type          rd_ent;
   pbs_pkg::dop_type            dop;
   logic signed [31:0]          dval;
   logic signed [33:0]          dres;
   logic                        flush;
   pbs_pkg::ovl_status_type     ovl_status;
   logic [JW-1:0]               ovl_idx;
   pbs_pkg::entry_type          ovl_entry;

   logic signed [31:0] nv;
   logic signed [31:0] nvy;
   logic signed [33:0] lx;
   logic signed [33:0] ly;
   logic signed [33:0] rr;
   logic signed [33:0] x34;
   logic signed [33:0] y34;

   assign r_idx  = req_tdata[5:0];
   assign r_vx   = req_tdata[37:6];
   assign r_vy   = req_tdata[69:38];
   assign r_rad  = req_tdata[79:70];
   assign rd_ent = pbs_pkg::entry_type'(rd_word);

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff   <= '0;
         bounce_ff <= 17'd65536;
         fric_ff   <= '0;
         limx_ff   <= '0;
         limy_ff   <= '0;
         pin_ff    <= '0;
      end else if (csr_we) begin
         unique case (pbs_pkg::csr_index_type'(csr_index))
            pbs_pkg::CSR_GRAVITY:  grav_ff   <= csr_wdata;
            pbs_pkg::CSR_BOUNCE:   bounce_ff <= csr_wdata[16:0];
            pbs_pkg::CSR_FRICTION: fric_ff   <= csr_wdata[30:0];
            pbs_pkg::CSR_LIMIT_X:  limx_ff   <= csr_wdata[15:0];
            pbs_pkg::CSR_LIMIT_Y:  limy_ff   <= csr_wdata[15:0];
            pbs_pkg::CSR_POINTS:   pin_ff    <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   pbs_ram #(
      .WIDTH (pbs_pkg::ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (wr_ent),
      .rd_addr (ram_raddr),
      .rd_data (rd_word)
   );

   pbs_divc u_divc (
      .clock  (clock),
      .op     (dop),
      .value  (dval),
      .bounce (bounce_ff),
      .result (dres)
   );

   pbs_overlap #(
      .IDX_W (JW)
   ) u_overlap (
      .clock     (clock),
      .reset     (reset),
      .flush     (flush),
      .in_valid  (s1_v_ff),
      .in_idx    (s1_j_ff),
      .in_entry  (rd_ent),
      .self_x    (x_ff),
      .self_y    (y_ff),
      .self_r    (r_ff),
      .status    (ovl_status),
      .out_idx   (ovl_idx),
      .out_entry (ovl_entry)
   );

   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      op_in        = op_ff;
      inr_in       = inr_ff;
      i_in         = i_ff;
      valx_in      = valx_ff;
      valy_in      = valy_ff;
      radi_in      = radi_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      r_in         = r_ff;
      incx_in      = incx_ff;
      incy_in      = incy_ff;
      dvx_in       = dvx_ff;
      dvy_in       = dvy_ff;
      dg_in        = dg_ff;
      gv_in        = gv_ff;
      fv_in        = fv_ff;
      wallx_in     = wallx_ff;
      wally_in     = wally_ff;
      hits_in      = hits_ff;
      n_in         = n_ff;
      wj_in        = wj_ff;
      s1_v_in      = 1'b0;
      s1_j_in      = s1_j_ff;
      hj_in        = hj_ff;
      hent_in      = hent_ff;
      ovx_in       = ovx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = i_ff;
      ram_raddr    = AW'(r_idx);
      wr_ent       = '0;
      dop          = pbs_pkg::DOP_DIV60;
      dval         = '0;
      flush        = 1'b0;
      nv           = dres[31:0];
      nvy          = vy_ff;
      lx           = $signed({2'b00, limx_ff, 16'h0000});
      ly           = $signed({2'b00, limy_ff, 16'h0000});
      rr           = $signed({8'h00, r_ff, 16'h0000});
      x34          = 34'(x_ff);
      y34          = 34'(y_ff);

      unique case (state_ff)
         pbs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in    = req_tuser;
               i_in     = AW'(r_idx);
               inr_in   = 32'(r_idx) < 32'(MAX_POINTS);
               valx_in  = r_vx;
               valy_in  = r_vy;
               radi_in  = r_rad;
               hits_in  = '0;
               state_in = pbs_pkg::ST_READ;
            end
         end

         pbs_pkg::ST_READ: begin
            x_in     = rd_ent.pos_x;
            y_in     = rd_ent.pos_y;
            vx_in    = rd_ent.vel_x;
            vy_in    = rd_ent.vel_y;
            r_in     = rd_ent.radius;
            state_in = pbs_pkg::ST_DONE;
            if (!inr_ff) begin
               x_in  = '0;
               y_in  = '0;
               vx_in = '0;
               vy_in = '0;
            end else begin
               unique case (pbs_pkg::opcode_type'(op_ff))
                  pbs_pkg::OPC_LOAD: begin
                     x_in          = valx_ff;
                     y_in          = valy_ff;
                     vx_in         = '0;
                     vy_in         = '0;
                     ram_we        = 1'b1;
                     wr_ent.pos_x  = valx_ff;
                     wr_ent.pos_y  = valy_ff;
                     wr_ent.radius = radi_ff;
                  end
                  pbs_pkg::OPC_FORCE: begin
                     vx_in  = pbs_pkg::sat32(36'(rd_ent.vel_x) + 36'(valx_ff));
                     vy_in  = pbs_pkg::sat32(36'(rd_ent.vel_y) + 36'(valy_ff));
                     ram_we = 1'b1;
                     wr_ent = rd_ent;
                     wr_ent.vel_x = vx_in;
                     wr_ent.vel_y = vy_in;
                  end
                  pbs_pkg::OPC_STEP: begin
                     if (32'(pin_ff) < 32'(MAX_POINTS)) begin
                        n_in = JW'(pin_ff);
                     end else begin
                        n_in = JW'(MAX_POINTS);
                     end
                     ph_in    = '0;
                     state_in = pbs_pkg::ST_DIV;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Five quotients go through the divide unit back to back.
         pbs_pkg::ST_DIV: begin
            ph_in = ph_ff + 3'd1;
            unique case (ph_ff)
               3'd0: begin
                  dop  = pbs_pkg::DOP_DIV60;
                  dval = vx_ff;
               end
               3'd1: begin
                  dop  = pbs_pkg::DOP_DIV60;
                  dval = vy_ff;
               end
               3'd2: begin
                  dop    = pbs_pkg::DOP_DIV7200;
                  dval   = grav_ff;
                  dvx_in = dres;
               end
               3'd3: begin
                  dop    = pbs_pkg::DOP_DIV60;
                  dval   = grav_ff;
                  dvy_in = dres;
               end
               3'd4: begin
                  dop   = pbs_pkg::DOP_DIV60;
                  dval  = $signed({1'b0, fric_ff});
                  dg_in = dres;
               end
               3'd5: begin
                  gv_in = dres;
               end
               default: begin
                  fv_in    = dres;
                  state_in = pbs_pkg::ST_INTEG;
               end
            endcase
         end

         pbs_pkg::ST_INTEG: begin
            x_in     = pbs_pkg::sat32(36'(x_ff) + 36'(dvx_ff));
            y_in     = pbs_pkg::sat32(36'(y_ff) + 36'(dvy_ff) + 36'(dg_ff));
            incx_in  = pbs_pkg::abs33(x_ff) - pbs_pkg::abs33(x_in);
            incy_in  = pbs_pkg::abs33(y_ff) - pbs_pkg::abs33(y_in);
            ph_in    = '0;
            state_in = pbs_pkg::ST_WALL;
         end

         pbs_pkg::ST_WALL: begin
            ph_in = ph_ff + 3'd1;
            unique case (ph_ff)
               3'd0: begin
                  dop      = pbs_pkg::DOP_REFLECT;
                  dval     = vx_ff;
                  wally_in = (y34 > ly) || (y34 <= rr);
                  wallx_in = (x34 >= lx) || (x34 <= rr);
                  if (y34 > ly) begin
                     y_in = ly[31:0];
                  end else if (y34 <= rr) begin
                     y_in = rr[31:0];
                  end
                  if (x34 >= lx) begin
                     x_in = lx[31:0];
                  end else if (x34 <= rr) begin
                     x_in = rr[31:0];
                  end
               end
               3'd1: begin
                  dop  = pbs_pkg::DOP_REFLECT;
                  dval = vy_ff;
               end
               3'd2: begin
                  if (wallx_ff) begin
                     vx_in = pbs_pkg::sat32(36'(dres));
                  end
               end
               default: begin
                  if (wally_ff) begin
                     vy_in = pbs_pkg::sat32(36'(dres));
                  end
                  wj_in    = '0;
                  state_in = pbs_pkg::ST_WALK;
               end
            endcase
         end

         // Entries stream through the distance pipeline; an overlap drains it
         // because it moves the stepped particle.
         pbs_pkg::ST_WALK: begin
            if (ovl_status.valid && ovl_status.hit) begin
               hj_in    = ovl_idx;
               hent_in  = ovl_entry;
               flush    = 1'b1;
               wj_in    = ovl_idx + JW'(1);
               ph_in    = '0;
               state_in = pbs_pkg::ST_HIT;
            end else if (wj_ff < n_ff) begin
               ram_raddr = wj_ff[AW-1:0];
               s1_v_in   = wj_ff[AW-1:0] != i_ff;
               s1_j_in   = wj_ff;
               wj_in     = wj_ff + JW'(1);
            end else if (!s1_v_ff && !ovl_status.busy) begin
               state_in = pbs_pkg::ST_FINAL;
            end
         end

         pbs_pkg::ST_HIT: begin
            ph_in = ph_ff + 3'd1;
            nv    = pbs_pkg::sat32(36'(dres));
            unique case (ph_ff)
               3'd0: begin
                  dop  = pbs_pkg::DOP_REFLECT;
                  dval = vx_ff;
                  x_in = pbs_pkg::sat32(36'(x_ff) + 36'(incx_ff));
                  y_in = pbs_pkg::sat32(36'(y_ff) + 36'(incy_ff));
               end
               3'd1: begin
                  dop  = pbs_pkg::DOP_REFLECT;
                  dval = vy_ff;
               end
               3'd2: begin
                  vx_in = nv;
                  dop   = pbs_pkg::DOP_REFLECT;
                  dval  = nv;
               end
               3'd3: begin
                  vy_in = nv;
                  dop   = pbs_pkg::DOP_REFLECT;
                  dval  = nv;
               end
               3'd4: begin
                  ovx_in = nv;
               end
               default: begin
                  ram_we        = 1'b1;
                  ram_waddr     = hj_ff[AW-1:0];
                  wr_ent        = hent_ff;
                  wr_ent.vel_x  = ovx_ff;
                  wr_ent.vel_y  = nv;
                  if (hits_ff != pbs_pkg::HIT_MAX) begin
                     hits_in = hits_ff + 6'd1;
                  end
                  state_in = pbs_pkg::ST_WALK;
               end
            endcase
         end

         pbs_pkg::ST_FINAL: begin
            if (!vx_ff[31] && (vx_ff != 32'sd0)) begin
               vx_in = pbs_pkg::sat32(36'(vx_ff) - 36'(fv_ff));
            end else if (vx_ff[31]) begin
               vx_in = pbs_pkg::sat32(36'(vx_ff) + 36'(fv_ff));
            end
            nvy           = pbs_pkg::sat32(36'(vy_ff) + 36'(gv_ff));
            vy_in         = nvy;
            ram_we        = 1'b1;
            wr_ent.pos_x  = x_ff;
            wr_ent.pos_y  = y_ff;
            wr_ent.vel_x  = vx_in;
            wr_ent.vel_y  = nvy;
            wr_ent.radius = r_ff;
            state_in      = pbs_pkg::ST_DONE;
         end

         pbs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, hits_ff, vy_ff, vx_ff, y_ff, x_ff};
               state_in     = pbs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbs_pkg::ST_IDLE;
         ph_ff        <= '0;
         s1_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         s1_v_ff      <= s1_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      inr_ff      <= inr_in;
      i_ff        <= i_in;
      valx_ff     <= valx_in;
      valy_ff     <= valy_in;
      radi_ff     <= radi_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      r_ff        <= r_in;
      incx_ff     <= incx_in;
      incy_ff     <= incy_in;
      dvx_ff      <= dvx_in;
      dvy_ff      <= dvy_in;
      dg_ff       <= dg_in;
      gv_ff       <= gv_in;
      fv_ff       <= fv_in;
      wallx_ff    <= wallx_in;
      wally_ff    <= wally_in;
      hits_ff     <= hits_in;
      n_ff        <= n_in;
      wj_ff       <= wj_in;
      s1_j_ff     <= s1_j_in;
      hj_ff       <= hj_in;
      hent_ff     <= hent_in;
      ovx_ff      <= ovx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == pbs_pkg::ST_IDLE |-> !ram_we)
      else $error("store written while idle");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == pbs_pkg::ST_WALK |-> wj_ff <= n_ff)
      else $error("walk index passed the walk length");

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == pbs_pkg::ST_READ)
      else $error("accepted item did not start a read");

   a_hit_flush: assert property (@(posedge clock) disable iff (reset)
      state_ff == pbs_pkg::ST_WALK && ovl_status.valid && ovl_status.hit
      |=> state_ff == pbs_pkg::ST_HIT && !ovl_status.valid)
      else $error("overlap did not drain the distance pipeline");

endmodule

/* design/pbs_ram.sv */
// ----------------------------------------------------------------------------
// pbs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pbs_divc.sv */
// ----------------------------------------------------------------------------
// pbs_divc
// Two-stage unit for rounded division by 60 or 7200 and bounce reflection.
// ----------------------------------------------------------------------------
module pbs_divc (
   input  logic                  clock,
   input  pbs_pkg::dop_type      op,
   input  logic signed [31:0]    value,
   input  logic [16:0]           bounce,
   output logic signed [33:0]    result
);

   logic                        neg;
   logic [31:0]                 mag;
   logic [31:0]                 num_in;
   logic [pbs_pkg::MUL_W-1:0]   mulb;
   logic [58:0]                 prod_in;
   logic [58:0]                 prod_ff;
   logic [31:0]                 num_ff;
   logic                        neg_ff;
   pbs_pkg::dop_type            op_ff;
   logic [26:0]                 q_est;
   logic [32:0]                 divisor;
   logic [32:0]                 rem;
   logic [32:0]                 q_div;
   logic [32:0]                 q_refl;
   logic [32:0]                 q_mag;
   logic                        positive;
   logic signed [33:0]          result_in;
   logic signed [33:0]          result_ff;

   always_comb begin
      neg = value[31];
      mag = neg ? (~value + 32'd1) : value;
      unique case (op)
         pbs_pkg::DOP_DIV60: begin
            num_in = mag + 32'd30;
            mulb   = pbs_pkg::DIV60_MUL;
         end
         pbs_pkg::DOP_DIV7200: begin
            num_in = mag + 32'd3600;
            mulb   = pbs_pkg::DIV7200_MUL;
         end
         pbs_pkg::DOP_REFLECT: begin
            num_in = mag;
            mulb   = pbs_pkg::MUL_W'(bounce);
         end
         default: begin
            num_in = mag;
            mulb   = '0;
         end
      endcase
      prod_in = 59'(num_in) * 59'(mulb);
   end

   // Second stage: correct the reciprocal estimate, or round the product.
   always_comb begin
      q_est    = prod_ff[58:32];
      divisor  = (op_ff == pbs_pkg::DOP_DIV7200) ? 33'd7200 : 33'd60;
      rem      = 33'(num_ff) - 33'(q_est) * divisor;
      q_div    = 33'(q_est) + ((rem >= divisor) ? 33'd1 : 33'd0);
      q_refl   = 33'((prod_ff + 59'd32768) >> 16);
      q_mag    = (op_ff == pbs_pkg::DOP_REFLECT) ? q_refl : q_div;
      positive = (op_ff == pbs_pkg::DOP_REFLECT) ? neg_ff : !neg_ff;
      result_in = positive ? $signed(34'(q_mag)) : -$signed(34'(q_mag));
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      num_ff    <= num_in;
      neg_ff    <= neg;
      op_ff     <= op;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

/* design/pbs_overlap.sv */
// ----------------------------------------------------------------------------
// pbs_overlap
// Three-stage distance test of one stored particle against the stepped one.
// ----------------------------------------------------------------------------
module pbs_overlap #(
   parameter int IDX_W = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        flush,
   input  logic                        in_valid,
   input  logic [IDX_W-1:0]            in_idx,
   input  pbs_pkg::entry_type          in_entry,
   input  logic signed [31:0]          self_x,
   input  logic signed [31:0]          self_y,
   input  logic [9:0]                  self_r,
   output pbs_pkg::ovl_status_type     status,
   output logic [IDX_W-1:0]            out_idx,
   output pbs_pkg::entry_type          out_entry
);

   logic signed [32:0]  dx;
   logic signed [32:0]  dy;
   logic [32:0]         adx_in;
   logic [32:0]         ady_in;
   logic [10:0]         rs_in;
   logic                s2_v_ff;
   logic [IDX_W-1:0]    s2_idx_ff;
   pbs_pkg::entry_type  s2_ent_ff;
   logic [32:0]         adx_ff;
   logic [32:0]         ady_ff;
   logic [10:0]         rs_ff;
   logic                s3_v_ff;
   logic [IDX_W-1:0]    s3_idx_ff;
   pbs_pkg::entry_type  s3_ent_ff;
   logic [65:0]         dx2_ff;
   logic [65:0]         dy2_ff;
   logic [21:0]         rs2_ff;
   logic [66:0]         dist_sq;

   always_comb begin
      dx     = 33'(in_entry.pos_x) - 33'(self_x);
      dy     = 33'(self_y) - 33'(in_entry.pos_y);
      adx_in = dx[32] ? 33'(-dx) : 33'(dx);
      ady_in = dy[32] ? 33'(-dy) : 33'(dy);
      rs_in  = 11'(self_r) + 11'(in_entry.radius);
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= in_valid;
         s3_v_ff <= s2_v_ff;
      end
      s2_idx_ff <= in_idx;
      s2_ent_ff <= in_entry;
      adx_ff    <= adx_in;
      ady_ff    <= ady_in;
      rs_ff     <= rs_in;
      s3_idx_ff <= s2_idx_ff;
      s3_ent_ff <= s2_ent_ff;
      dx2_ff    <= 66'(adx_ff) * 66'(adx_ff);
      dy2_ff    <= 66'(ady_ff) * 66'(ady_ff);
      rs2_ff    <= 22'(rs_ff) * 22'(rs_ff);
   end

   // The summed radius is in whole pixels, so its square sits 32 bits up.
   assign dist_sq      = 67'(dx2_ff) + 67'(dy2_ff);
   assign status.busy  = s2_v_ff | s3_v_ff;
   assign status.valid = s3_v_ff;
   assign status.hit   = dist_sq <= 67'({rs2_ff, 32'h0000_0000});
   assign out_idx      = s3_idx_ff;
   assign out_entry    = s3_ent_ff;

endmodule

/* dv/particle_step_with_bounce_test.sv */
// ----------------------------------------------------------------------------
// particle_step_with_bounce_test
// Self-checking bench for the particle store: a directed table, then phases of
// random loads, forces, steps and unused opcodes under changing register settings,
// each result compared field by field with its table row or an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module particle_step_with_bounce_test;

   localparam int NPTS = 64;
   localparam logic [pbs_pkg::OPC_W-1:0] OPC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 10000000;
   localparam int NUM_PHASES = 8;
   localparam int PHASE_ITEMS = 205;

   typedef struct {
      logic signed [31:0]        pos_x;
      logic signed [31:0]        pos_y;
      logic signed [31:0]        vel_x;
      logic signed [31:0]        vel_y;
      logic [pbs_pkg::HIT_W-1:0] hits;
   } particle_result_type;

   typedef struct {
      logic [pbs_pkg::OPC_W-1:0] op;
      logic [5:0]                idx;
      logic signed [31:0]        vx;
      logic signed [31:0]        vy;
      logic [9:0]                rad;
      bit                        typed;
      particle_result_type       res;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [pbs_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [pbs_pkg::OPC_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [pbs_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [pbs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pbs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   particle_step_with_bounce u_top (.*);

   // Predictor state.
   longint grav_q, bounce_q, fric_q, wall_x, floor_y;
   int unsigned walk_n;
   logic signed [31:0] px [NPTS];
   logic signed [31:0] py [NPTS];
   logic signed [31:0] pvx [NPTS];
   logic signed [31:0] pvy [NPTS];
   logic [9:0] prad [NPTS];

   particle_result_type pending_results[$];
   int errors = 0;
   int cycles = 0;
   bit calm = 1'b0;
   bit stim_done = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[particle_step_with_bounce] ERROR");
         $finish;
      end
   end

   function automatic longint sat_q(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint round_div(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic logic signed [31:0] bounce_back(logic signed [31:0] v);
      return 32'(sat_q(-round_div(longint'(v) * bounce_q, 65536)));
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [pbs_pkg::HIT_W-1:0] integrate(int i);
      longint x, y, vx, vy, r, inc_x, inc_y, rs, fdt;
      longint unsigned dx2, dy2, dsum, rr;
      int n;
      int hits;
      x = px[i]; y = py[i]; vx = pvx[i]; vy = pvy[i]; r = prad[i];
      hits = 0;
      inc_x = mag(x);
      inc_y = mag(y);
      x = sat_q(x + round_div(vx, 60));
      y = sat_q(y + round_div(vy, 60) + round_div(grav_q, 7200));
      inc_x -= mag(x);
      inc_y -= mag(y);
      // A wall far out wraps to a negative position, as the stored word does.
      if (y > floor_y * 65536) begin
         y = 32'(floor_y * 65536);
         vy = bounce_back(32'(vy));
      end else if (y <= r * 65536) begin
         y = 32'(r * 65536);
         vy = bounce_back(32'(vy));
      end
      if (x >= wall_x * 65536) begin
         x = 32'(wall_x * 65536);
         vx = bounce_back(32'(vx));
      end else if (x <= r * 65536) begin
         x = 32'(r * 65536);
         vx = bounce_back(32'(vx));
      end
      n = walk_n < NPTS ? walk_n : NPTS;
      for (int j = 0; j < n; j++) begin
         if (j == i) continue;
         dx2 = longint'(mag(longint'(px[j]) - x)) * longint'(mag(longint'(px[j]) - x));
         dy2 = longint'(mag(y - longint'(py[j]))) * longint'(mag(y - longint'(py[j])));
         dsum = (dx2 > ~64'd0 - dy2) ? ~64'd0 : dx2 + dy2;
         rs = (r + longint'(prad[j])) * 65536;
         rr = rs * rs;
         if (dsum <= rr) begin
            vx = bounce_back(32'(vx));
            vy = bounce_back(32'(vy));
            x = sat_q(x + inc_x);
            y = sat_q(y + inc_y);
            pvx[j] = bounce_back(32'(vx));
            pvy[j] = bounce_back(32'(vy));
            if (hits < 63) hits++;
         end
      end
      fdt = round_div(fric_q, 60);
      if (vx > 0) vx = sat_q(vx - fdt);
      else if (vx < 0) vx = sat_q(vx + fdt);
      vy = sat_q(vy + round_div(grav_q, 60));
      px[i] = 32'(x); py[i] = 32'(y); pvx[i] = 32'(vx); pvy[i] = 32'(vy);
      return pbs_pkg::HIT_W'(hits);
   endfunction

   function automatic particle_result_type predict_particle(
         logic [pbs_pkg::OPC_W-1:0] op, int i,
         logic signed [31:0] vx, logic signed [31:0] vy, logic [9:0] rad);
      particle_result_type res;
      res.hits = '0;
      case (op)
         pbs_pkg::OPC_LOAD: begin
            px[i] = vx; py[i] = vy; pvx[i] = 0; pvy[i] = 0; prad[i] = rad;
         end
         pbs_pkg::OPC_FORCE: begin
            pvx[i] = 32'(sat_q(longint'(pvx[i]) + longint'(vx)));
            pvy[i] = 32'(sat_q(longint'(pvy[i]) + longint'(vy)));
         end
         pbs_pkg::OPC_STEP: res.hits = integrate(i);
         default: ;
      endcase
      res.pos_x = px[i]; res.pos_y = py[i]; res.vel_x = pvx[i]; res.vel_y = pvy[i];
      return res;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      errors++;
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
   endtask

   task automatic write_reg(pbs_pkg::csr_index_type idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         pbs_pkg::CSR_GRAVITY:  grav_q = longint'(signed'(value));
         pbs_pkg::CSR_BOUNCE:   bounce_q = value[16:0];
         pbs_pkg::CSR_FRICTION: fric_q = value[30:0];
         pbs_pkg::CSR_LIMIT_X:  wall_x = value[15:0];
         pbs_pkg::CSR_LIMIT_Y:  floor_y = value[15:0];
         pbs_pkg::CSR_POINTS:   walk_n = value[6:0];
         default: ;
      endcase
   endtask

   // Drives one item, waits for its acceptance and queues its expected result.
   task automatic send_item(logic [pbs_pkg::OPC_W-1:0] op, logic [5:0] idx,
         logic signed [31:0] vx, logic signed [31:0] vy, logic [9:0] rad, bit typed,
         particle_result_type typed_res);
      particle_result_type res;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {rad, vy, vx, idx};
      do @(posedge clock); while (!req_tready);
      res = predict_particle(op, idx, vx, vy, rad);
      pending_results.push_back(typed ? typed_res : res);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Result side: random stall bursts, checked against the oldest expectation.
   initial begin
      int stall;
      particle_result_type want;
      particle_result_type got;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.pos_x = rsp_tdata[31:0];
            got.pos_y = rsp_tdata[63:32];
            got.vel_x = rsp_tdata[95:64];
            got.vel_y = rsp_tdata[127:96];
            got.hits = rsp_tdata[133:128];
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               want = pending_results.pop_front();
               if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
               if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
               if (got.vel_x !== want.vel_x) report_mismatch("vel_x", got.vel_x, want.vel_x);
               if (got.vel_y !== want.vel_y) report_mismatch("vel_y", got.vel_y, want.vel_y);
               if (got.hits !== want.hits) report_mismatch("hit_count", got.hits, want.hits);
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 11) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !reset;
         end
      end
   end

   function automatic table_row_type row(logic [pbs_pkg::OPC_W-1:0] op, logic [5:0] idx,
         logic signed [31:0] vx, logic signed [31:0] vy, logic [9:0] rad, bit typed,
         logic signed [31:0] ex, logic signed [31:0] ey, logic signed [31:0] evx,
         logic signed [31:0] evy);
      table_row_type t;
      t.op = op; t.idx = idx; t.vx = vx; t.vy = vy; t.rad = rad; t.typed = typed;
      t.res.pos_x = ex; t.res.pos_y = ey; t.res.vel_x = evx; t.res.vel_y = evy;
      t.res.hits = '0;
      return t;
   endfunction

   initial begin
      table_row_type rows[$];
      particle_result_type none;
      logic signed [31:0] base_x, base_y, vx, vy;
      logic [pbs_pkg::OPC_W-1:0] op;
      int pick, lim;
      none = '{default: '0};
      grav_q = 0; bounce_q = 65536; fric_q = 0; wall_x = 0; floor_y = 0; walk_n = 0;
      for (int i = 0; i < NPTS; i++) begin
         px[i] = 0; py[i] = 0; pvx[i] = 0; pvy[i] = 0; prad[i] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with the reset register values.
      rows.push_back(row(pbs_pkg::OPC_LOAD, 0, 32'sh7FFFFFFF, 32'sh80000000, 1023, 1,
                         32'sh7FFFFFFF, 32'sh80000000, 0, 0));
      rows.push_back(row(pbs_pkg::OPC_LOAD, 63, 0, 0, 0, 1, 0, 0, 0, 0));
      rows.push_back(row(pbs_pkg::OPC_LOAD, 1, 32'sh80000000, 32'sh7FFFFFFF, 0, 1,
                         32'sh80000000, 32'sh7FFFFFFF, 0, 0));
      rows.push_back(row(pbs_pkg::OPC_FORCE, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 1,
                         32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000));
      // A second force saturates the velocity.
      rows.push_back(row(pbs_pkg::OPC_FORCE, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 1,
                         32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000));
      rows.push_back(row(OPC_UNUSED, 63, 32'sh12345678, 1, 5, 1, 0, 0, 0, 0));
      rows.push_back(row(pbs_pkg::OPC_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(row(pbs_pkg::OPC_STEP, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(row(pbs_pkg::OPC_STEP, 63, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(row(pbs_pkg::OPC_FORCE, 1, 32'sh80000000, 32'sh7FFFFFFF, 0, 0,
                         0, 0, 0, 0));
      rows.push_back(row(pbs_pkg::OPC_STEP, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(row(pbs_pkg::OPC_LOAD, 2, 32'sh00640000, 32'sh00640000, 10, 0,
                         0, 0, 0, 0));
      rows.push_back(row(pbs_pkg::OPC_FORCE, 2, -32'sh00010000, 32'sh00500000, 0, 0,
                         0, 0, 0, 0));
      rows.push_back(row(pbs_pkg::OPC_STEP, 2, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(row(OPC_UNUSED, 2, 0, 0, 0, 0, 0, 0, 0, 0));
      foreach (rows[k])
         send_item(rows[k].op, rows[k].idx, rows[k].vx, rows[k].vy, rows[k].rad,
                   rows[k].typed, rows[k].res);
      drain();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         calm = (ph == NUM_PHASES - 1);
         lim = $urandom_range(100, 400);
         write_reg(pbs_pkg::CSR_GRAVITY, ph == 1 ? 32'h7FFFFFFF : ph == 2 ? 32'h80000000 :
                   32'($urandom_range(0, 40000)) - 32'd20000);
         write_reg(pbs_pkg::CSR_BOUNCE, ph == 1 ? 0 : ph == 2 ? 32'h1FFFF :
                   ph == 3 ? 65536 : $urandom_range(0, 65536));
         write_reg(pbs_pkg::CSR_FRICTION, ph == 2 ? 32'h7FFFFFFF : ph == 1 ? 0 :
                   $urandom_range(0, 2000000));
         write_reg(pbs_pkg::CSR_LIMIT_X, ph == 1 ? 0 : ph == 2 ? 16'hFFFF : lim);
         write_reg(pbs_pkg::CSR_LIMIT_Y, ph == 1 ? 16'hFFFF : ph == 2 ? 0 : lim);
         write_reg(pbs_pkg::CSR_POINTS, ph == 0 ? 0 : ph == 3 ? 64 : ph == 2 ? 127 :
                   $urandom_range(2, 64));
         csr_we <= 1'b0;

         // Every entry is loaded before any walk can reach it; the cluster
         // phase stacks them all in one spot so the hit count saturates.
         base_x = 32'(lim / 2) <<< 16;
         base_y = 32'(lim / 2) <<< 16;
         if (ph == 0 || ph == 3)
            for (int i = 0; i < NPTS; i++) begin
               vx = ph == 3 ? base_x : 32'($urandom_range(0, lim)) <<< 16;
               vy = ph == 3 ? base_y : 32'($urandom_range(0, lim)) <<< 16;
               send_item(pbs_pkg::OPC_LOAD, 6'(i), vx, vy, 10'($urandom_range(1, 40)),
                         0, none);
            end

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            vx = 32'($urandom_range(0, 2 * lim)) <<< 16 | 32'($urandom_range(0, 65535));
            vy = 32'($urandom_range(0, 2 * lim)) <<< 16 | 32'($urandom_range(0, 65535));
            if (pick < 25) begin
               op = pbs_pkg::OPC_LOAD;
            end else if (pick < 50) begin
               op = pbs_pkg::OPC_FORCE;
               vx = 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
               vy = 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
            end else if (pick < 90) begin
               op = pbs_pkg::OPC_STEP;
            end else if (pick < 95) begin
               op = OPC_UNUSED;
            end else begin
               op = $urandom_range(0, 1) ? pbs_pkg::OPC_LOAD : pbs_pkg::OPC_FORCE;
               vx = $urandom;
               vy = $urandom;
            end
            send_item(op, 6'($urandom_range(0, NPTS - 1)), vx, vy,
                      10'(pick >= 95 ? $urandom_range(0, 1023) : $urandom_range(1, 40)),
                      0, none);
         end
         drain();
      end

      if (errors == 0) begin
         $display("[particle_step_with_bounce] OK");
      end else begin
         $display("[particle_step_with_bounce] ERROR");
      end
      $finish;
   end

endmodule
